// File: sv/binary_trie_address_allocator_assert.svh
// assertion macros for the binary trie address allocator
// used by modules that include this file; needs clk_i and rst_ni in scope
`ifndef BINARY_TRIE_ADDRESS_ALLOCATOR_ASSERT_SVH
`define BINARY_TRIE_ADDRESS_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BTAA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btaa assertion failed");
`define BTAA_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("btaa assertion failed");
`else
`define BTAA_ASSERT(label, prop)
`define BTAA_ASSERT_IMPL(label, pre, post)
`endif
`endif

// File: sv/btaa_pkg.sv
// package for the binary trie address allocator
// types, codes and sizes shared by the leaf memory and the top level
package btaa_pkg;
  localparam int unsigned AddrBits  = 8;
  localparam int unsigned WordBits  = 16;
  localparam int unsigned PosBits   = 4;
  localparam int unsigned WordCount = 16;
  localparam int unsigned WordIdxW  = 4;

  typedef logic [WordIdxW-1:0] word_idx_t;
  typedef logic [WordBits-1:0] leaf_word_t;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_DOUBLE_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_RESP
  } state_e;

  // request from the controller to the leaf memory
  typedef struct packed {
    logic       clr;
    logic       re;
    word_idx_t  raddr;
    logic       we;
    word_idx_t  waddr;
    leaf_word_t wdata;
  } mem_req_t;
endpackage

// File: sv/btaa_leaf_mem.sv
// leaf mark memory: 16 words of 16 leaf marks, registered read
// per-word valid flops make a cleared word read as all free; uses btaa_pkg
module btaa_leaf_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btaa_pkg::mem_req_t  req_i,
  output btaa_pkg::leaf_word_t rdata_o
);
  import btaa_pkg::*;

  leaf_word_t mem_q [WordCount];
  leaf_word_t rdata_q;
  logic [WordCount-1:0] valid_q;
  logic rvalid_q;

  // storage array and read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // word valid bits, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else if (req_i.clr) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;
endmodule

// File: sv/binary_trie_address_allocator.sv
// top level of the binary trie address allocator
// controller and word search over btaa_leaf_mem; uses btaa_pkg and the assert header
//
// usage: one word in (mode_i, address_i) on in_valid_i / in_stall_o, one word out
// on out_valid_o / out_stall_i for every word in. a word is taken at a rising edge
// with valid high and stall low. tree_height is written by cfg_we_i / cfg_wdata_i;
// the user must write it only while idle, the block does not enforce this; a write
// empties all addresses. a query goes from idle straight to its result; a release
// reads and evaluates one word; an allocate reads and evaluates words in turn, up to
// max(1,2^h/16) + 1 reads. the search is bounded by the single read port of the leaf
// memory; each word read passes through the read state and then the evaluate state.
// one word is worked on at a time; a new word is taken as soon as the prior result
// sits in the output register, even while the receiver stalls it.
// reset empties the tree at once (word valid flops), height returns to 8, no pass.
// a stalled result holds its fields until taken; the block waits to deliver.
`include "binary_trie_address_allocator_assert.svh"
module binary_trie_address_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] address_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] given_address_o,
  output logic [1:0] status_o,
  output logic [8:0] free_count_o,
  output logic       tree_full_o
);
  import btaa_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] height_q;
  logic [8:0] alloc_q, alloc_d;
  mode_e      mode_q;
  logic [7:0] addr_q;
  word_idx_t  word_q, word_d;
  logic       first_q, first_d;
  logic [7:0] res_addr_q, res_addr_d;
  status_e    res_st_q, res_st_d;
  logic       out_valid_q;
  logic [7:0] out_addr_q;
  logic [1:0] out_st_q;
  logic [8:0] out_free_q;
  logic       out_full_q;

  mem_req_t   req;
  leaf_word_t rdata;

  logic [3:0] heff;
  logic [8:0] leaves;
  word_idx_t  wmask;
  leaf_word_t vmask;
  logic [7:0] amask;
  logic       accept;
  leaf_word_t free_bits;
  logic       found;
  logic [PosBits-1:0] fpos;
  logic       leaf_set;
  logic       out_load;

  // effective height and derived sizes
  always_comb begin
    heff = height_q;
    if (heff == 4'd0) heff = 4'd1;
    if (heff > 4'(AddrBits)) heff = 4'(AddrBits);
    leaves = 9'd1 << heff;
    amask  = 8'(leaves - 9'd1);
    wmask  = (heff <= 4'd4) ? '0 : word_idx_t'((9'd1 << (heff - 4'd4)) - 9'd1);
    vmask  = (heff >= 4'd4) ? '1 : leaf_word_t'((17'd1 << leaves[4:0]) - 17'd1);
  end

  btaa_leaf_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  // free leaves in the word just read, lowest one first
  always_comb begin
    free_bits = ~rdata & vmask;
    if (first_q) free_bits = free_bits & (leaf_word_t'('1) << addr_q[PosBits-1:0]);
    found = |free_bits;
    fpos  = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (free_bits[i]) fpos = PosBits'(i);
    end
    leaf_set = rdata[addr_q[PosBits-1:0]];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_e'(mode_i) == MODE_RELEASE) state_d = S_READ;
          else if (mode_e'(mode_i) == MODE_ALLOC && alloc_q != leaves) state_d = S_READ;
          else state_d = S_RESP;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (mode_q == MODE_RELEASE || found) state_d = S_RESP;
        else state_d = S_READ;
      end
      S_RESP: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    req        = '0;
    req.clr    = cfg_we_i;
    alloc_d    = alloc_q;
    word_d     = word_q;
    first_d    = first_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    if (cfg_we_i) alloc_d = '0;
    unique case (state_q)
      S_IDLE: begin
        word_d     = word_idx_t'((address_i & amask) >> PosBits);
        first_d    = 1'b1;
        res_addr_d = '0;
        res_st_d   = (mode_e'(mode_i) == MODE_ALLOC) ? ST_FULL : ST_OK;
      end
      S_READ: begin
        req.re    = 1'b1;
        req.raddr = word_q;
      end
      S_EVAL: begin
        req.waddr = word_q;
        if (mode_q == MODE_RELEASE) begin
          if (leaf_set) begin
            req.we    = 1'b1;
            req.wdata = rdata & ~(leaf_word_t'(1) << addr_q[PosBits-1:0]);
            alloc_d   = alloc_q - 9'd1;
            res_st_d  = ST_OK;
          end else begin
            res_st_d  = ST_DOUBLE_FREE;
          end
        end else if (found) begin
          req.we     = 1'b1;
          req.wdata  = rdata | (leaf_word_t'(1) << fpos);
          alloc_d    = alloc_q + 9'd1;
          res_addr_d = {word_q, fpos} & amask;
          res_st_d   = ST_OK;
        end else begin
          word_d  = (word_q + word_idx_t'(1)) & wmask;
          first_d = 1'b0;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      height_q    <= 4'd8;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_d;
      if (cfg_we_i) height_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    first_q    <= first_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (accept) begin
      mode_q <= (mode_e'(mode_i) == MODE_SPARE) ? MODE_QUERY : mode_e'(mode_i);
      addr_q <= address_i & amask;
    end
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
      out_free_q <= leaves - alloc_q;
      out_full_q <= (alloc_q == leaves);
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign given_address_o = out_addr_q;
  assign status_o        = out_st_q;
  assign free_count_o    = out_free_q;
  assign tree_full_o     = out_full_q;

  `BTAA_ASSERT(a_alloc_bound, alloc_q <= leaves)
  `BTAA_ASSERT_IMPL(a_out_hold, out_valid_q && out_stall_i, ##1 out_valid_q)
  `BTAA_ASSERT_IMPL(a_we_eval, req.we, state_q == S_EVAL)
  `BTAA_ASSERT_IMPL(a_read_then_eval, state_q == S_READ, ##1 state_q == S_EVAL)
endmodule

// File: tb/sv/tb.sv
// testbench for the binary trie address allocator
// drives request words, predicts each result from a local model of the tree
// depends on btaa_pkg and the binary_trie_address_allocator top level
`timescale 1ns / 100ps

class alloc_scoreboard;
  bit          leaf_used[256];
  int unsigned used_total;
  int unsigned height;
  int unsigned errors;
  logic [7:0]  exp_addr_q[$];
  logic [1:0]  exp_status_q[$];
  logic [8:0]  exp_free_q[$];
  logic        exp_full_q[$];

  function new();
    height = 8;
    errors = 0;
    clear_tree();
  endfunction

  function void clear_tree();
    for (int i = 0; i < 256; i++) leaf_used[i] = 1'b0;
    used_total = 0;
  endfunction

  // a height write empties the tree
  function void set_height(int unsigned h);
    height = h;
    clear_tree();
  endfunction

  // predict the result of an accepted request word
  function void note_request(logic [1:0] mode, logic [7:0] address);
    int unsigned h;
    int unsigned leaves;
    int unsigned a;
    int unsigned tries;
    logic [7:0]  granted;
    btaa_pkg::status_e st;
    h = (height < 1) ? 1 : ((height > 8) ? 8 : height);
    leaves = 1 << h;
    a = address & (leaves - 1);
    granted = '0;
    st = btaa_pkg::ST_OK;
    if (mode == btaa_pkg::MODE_ALLOC) begin
      if (used_total == leaves) begin
        st = btaa_pkg::ST_FULL;
      end else begin
        for (tries = 0; tries < leaves; tries++) begin
          if (!leaf_used[a]) break;
          a = (a + 1 == leaves) ? 0 : a + 1;
        end
        leaf_used[a] = 1'b1;
        used_total++;
        granted = a[7:0];
      end
    end else if (mode == btaa_pkg::MODE_RELEASE) begin
      if (!leaf_used[a]) begin
        st = btaa_pkg::ST_DOUBLE_FREE;
      end else begin
        leaf_used[a] = 1'b0;
        used_total--;
      end
    end
    exp_addr_q.push_back(granted);
    exp_status_q.push_back(st);
    exp_free_q.push_back(9'(leaves - used_total));
    exp_full_q.push_back(used_total == leaves);
  endfunction

  // compare a result word against the oldest prediction
  function void check_result(logic [7:0] ga, logic [1:0] st, logic [8:0] fc, logic tf);
    if (exp_addr_q.size() == 0) begin
      $display("%0t: unexpected result addr %0d status %0d", $time, ga, st);
      errors++;
      return;
    end
    if (ga !== exp_addr_q[0]) begin
      $display("%0t: given_address expected %0d actual %0d", $time, exp_addr_q[0], ga);
      errors++;
    end
    if (st !== exp_status_q[0]) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_status_q[0], st);
      errors++;
    end
    if (fc !== exp_free_q[0]) begin
      $display("%0t: free_count expected %0d actual %0d", $time, exp_free_q[0], fc);
      errors++;
    end
    if (tf !== exp_full_q[0]) begin
      $display("%0t: tree_full expected %0d actual %0d", $time, exp_full_q[0], tf);
      errors++;
    end
    void'(exp_addr_q.pop_front());
    void'(exp_status_q.pop_front());
    void'(exp_free_q.pop_front());
    void'(exp_full_q.pop_front());
  endfunction

  function int unsigned pending();
    return exp_addr_q.size();
  endfunction
endclass

module tb;
  import btaa_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] mode_i;
  logic [7:0] address_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] given_address_o;
  logic [1:0] status_o;
  logic [8:0] free_count_o;
  logic       tree_full_o;

  alloc_scoreboard sb;
  int unsigned live_height;
  int unsigned phase;

  binary_trie_address_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .address_i(address_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .given_address_o(given_address_o), .status_o(status_o),
    .free_count_o(free_count_o), .tree_full_o(tree_full_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // result side: random stall, check each taken word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(given_address_o, status_o, free_count_o, tree_full_o);
  end

  initial begin
    int unsigned g;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase == 1) begin
        out_stall_i <= 1'b0;
      end else begin
        g = gap_len();
        out_stall_i <= (g != 0);
        repeat (g > 1 ? g - 1 : 0) @(posedge clk_i);
        if (g != 0) begin
          @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // send one request word and wait for its acceptance; valid stays up
  // after acceptance so that a following word can go back to back
  task automatic send_word(logic [1:0] mode, logic [7:0] address, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    address_i <= address;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, address);
  endtask

  // write the height once the block is idle
  task automatic write_height(logic [3:0] h);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_height(h);
    live_height = (h < 1) ? 1 : ((h > 8) ? 8 : h);
  endtask

  // random mix: mostly allocates and releases of held addresses
  task automatic random_words(int unsigned n);
    int unsigned r;
    logic [7:0] a;
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      a = 8'($urandom_range(0, 255));
      if (r < 50) begin
        m = MODE_ALLOC;
      end else if (r < 85) begin
        m = MODE_RELEASE;
        for (int k = 0; k < 8; k++) begin
          if (sb.leaf_used[a & ((1 << live_height) - 1)]) break;
          a = 8'($urandom_range(0, 255));
        end
      end else begin
        m = 2'($urandom_range(MODE_QUERY, MODE_SPARE));
      end
      send_word(m, a, 1'b1);
    end
  endtask

  initial begin
    sb = new();
    phase = 0;
    live_height = 8;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_QUERY;
    address_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes at reset height, back to back
    phase = 1;
    send_word(MODE_ALLOC, 8'hff, 1'b0);
    send_word(MODE_ALLOC, 8'hff, 1'b0);
    send_word(MODE_ALLOC, 8'h00, 1'b0);
    send_word(MODE_RELEASE, 8'h10, 1'b0);
    send_word(MODE_RELEASE, 8'hff, 1'b0);
    send_word(MODE_QUERY, 8'haa, 1'b0);
    send_word(MODE_SPARE, 8'h55, 1'b0);
    // height 1: fill, full alloc, double free, wide address bits ignored
    write_height(4'd1);
    send_word(MODE_ALLOC, 8'hfe, 1'b0);
    send_word(MODE_ALLOC, 8'hfe, 1'b0);
    send_word(MODE_ALLOC, 8'h01, 1'b0);
    send_word(MODE_RELEASE, 8'hff, 1'b0);
    send_word(MODE_RELEASE, 8'h01, 1'b0);
    send_word(MODE_ALLOC, 8'h03, 1'b0);
    // height zero and above range clamp
    write_height(4'd0);
    send_word(MODE_ALLOC, 8'h01, 1'b0);
    send_word(MODE_QUERY, 8'h00, 1'b0);
    write_height(4'd15);
    send_word(MODE_ALLOC, 8'h80, 1'b0);
    send_word(MODE_RELEASE, 8'h7f, 1'b0);
    phase = 0;

    // random phases over several heights, filling small trees
    for (int p = 0; p < 10; p++) begin
      write_height(4'(p == 0 ? 8 : (p == 1 ? 1 : $urandom_range(0, 15))));
      random_words(p < 2 ? 40 : 80);
    end
    write_height(4'd8);
    for (int i = 0; i < 256; i++) send_word(MODE_ALLOC, 8'($urandom_range(0, 255)), 1'b1);
    send_word(MODE_ALLOC, 8'h00, 1'b1);
    random_words(40);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
